// ----- hw/rtl/olb_pkg.sv -----
// Shared types and constants for the overlap linear blend block.
// No dependencies; used by every module of the block.
package olb_pkg;

  localparam int POS_W    = 13;  // canvas coordinate width
  localparam int DIM_W    = 13;  // image size and overlap width registers
  localparam int SHY_W    = 14;  // vertical offset register, two's complement
  localparam int CMP_W    = 16;  // signed width that holds every classify term
  localparam int CHANNELS = 3;   // red, green, blue lanes
  localparam int CFG_W    = 14;  // widest configuration register
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    REG_BLACK = 2'd0,
    REG_A     = 2'd1,
    REG_B     = 2'd2,
    REG_BLEND = 2'd3
  } region_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_A  = 3'd0,
    CFG_HEIGHT_A = 3'd1,
    CFG_HEIGHT_B = 3'd2,
    CFG_SHIFT_X  = 3'd3,
    CFG_SHIFT_Y  = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic    valid;
    region_t region;
  } olb_ctl_t;

endpackage

// ----- hw/rtl/olb_classify.sv -----
// Entry stage: classifies a canvas position and derives the blend weights.
// Depends on olb_pkg.
module olb_classify import olb_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [POS_W-1:0]                     pos_x,
  input  logic [POS_W-1:0]                     pos_y,
  input  logic [CHANNELS-1:0][PIXEL_BITS-1:0]  a_in,
  input  logic [CHANNELS-1:0][PIXEL_BITS-1:0]  b_in,
  input  logic [DIM_W-1:0]                     width_a,
  input  logic [DIM_W-1:0]                     height_a,
  input  logic [DIM_W-1:0]                     height_b,
  input  logic [DIM_W-1:0]                     shift_x,
  input  logic [SHY_W-1:0]                     shift_y,
  output olb_ctl_t                             ctl,
  output logic [DIM_W-1:0]                     wt_a,
  output logic [DIM_W-1:0]                     wt_b,
  output logic [CHANNELS-1:0][PIXEL_BITS-1:0]  a_px,
  output logic [CHANNELS-1:0][PIXEL_BITS-1:0]  b_px
);

  logic signed [CMP_W-1:0] xs, ys, wa_s, ha_s, hb_s, dx_s, dy_s, off_s, wa_x, x_off;
  logic                    dy_pos, in_a, b_ok;
  region_t                 region_next;

  always_comb begin
    xs    = signed'({{(CMP_W-POS_W){1'b0}}, pos_x});
    ys    = signed'({{(CMP_W-POS_W){1'b0}}, pos_y});
    wa_s  = signed'({{(CMP_W-DIM_W){1'b0}}, width_a});
    ha_s  = signed'({{(CMP_W-DIM_W){1'b0}}, height_a});
    hb_s  = signed'({{(CMP_W-DIM_W){1'b0}}, height_b});
    dx_s  = signed'({{(CMP_W-DIM_W){1'b0}}, shift_x});
    dy_s  = signed'({{(CMP_W-SHY_W){shift_y[SHY_W-1]}}, shift_y});
    off_s = wa_s - dx_s;
    wa_x  = wa_s - xs;
    x_off = xs - off_s;
    dy_pos = (dy_s > 0);
    if (dy_pos) begin
      in_a = (xs < wa_s) && (ys >= dy_s);
      b_ok = (xs >= off_s) && (ys < hb_s);
    end else begin
      in_a = (xs < wa_s) && (ys < ha_s);
      b_ok = (xs >= off_s) && (ys >= -dy_s) && (ys < hb_s - dy_s);
    end
    if (in_a) begin
      region_next = b_ok ? REG_BLEND : REG_A;
    end else begin
      region_next = b_ok ? REG_B : REG_BLACK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= in_valid;
    end
    if (en) begin
      ctl.region <= region_next;
    end
  end

  // Weights only matter in the overlap, where both lie in 0..shift_x.
  always_ff @(posedge clk) begin
    if (en) begin
      wt_a       <= wa_x[DIM_W-1:0];
      wt_b       <= x_off[DIM_W-1:0];
      a_px       <= a_in;
      b_px       <= b_in;
    end
  end

endmodule

// ----- hw/rtl/olb_lane.sv -----
// One color lane: weighted sum, then a pipelined restoring divide by shift_x.
// Depends on olb_pkg.
module olb_lane import olb_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [DIM_W-1:0]      shift_x,
  input  logic [PIXEL_BITS-1:0] a_in,
  input  logic [PIXEL_BITS-1:0] b_in,
  input  logic [DIM_W-1:0]      wt_a,
  input  logic [DIM_W-1:0]      wt_b,
  output logic [PIXEL_BITS-1:0] quo,
  output logic [PIXEL_BITS-1:0] a_out,
  output logic [PIXEL_BITS-1:0] b_out
);

  localparam int NUM_W = PIXEL_BITS + DIM_W;

  // Stage s holds the item after s divide steps; stage 0 is the weighted sum.
  logic [NUM_W-1:0]      rem   [PIXEL_BITS+1];
  logic [PIXEL_BITS-1:0] qacc  [PIXEL_BITS+1];
  logic [PIXEL_BITS-1:0] a_d   [PIXEL_BITS+1];
  logic [PIXEL_BITS-1:0] b_d   [PIXEL_BITS+1];
  logic [NUM_W-1:0]      prod_a, prod_b;

  assign prod_a = NUM_W'(a_in) * NUM_W'(wt_a);
  assign prod_b = NUM_W'(b_in) * NUM_W'(wt_b);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= prod_a + prod_b;
      qacc[0] <= '0;
      a_d[0]  <= a_in;
      b_d[0]  <= b_in;
    end
  end

  // In the overlap the quotient fits in PIXEL_BITS because the weights sum to shift_x.
  for (genvar i = 0; i < PIXEL_BITS; i++) begin : g_step
    logic [NUM_W-1:0] dv;
    logic             take;
    assign dv   = NUM_W'(shift_x) << (PIXEL_BITS - 1 - i);
    assign take = (rem[i] >= dv);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= take ? (rem[i] - dv) : rem[i];
        qacc[i+1] <= (qacc[i] << 1) | PIXEL_BITS'(take);
        a_d[i+1]  <= a_d[i];
        b_d[i+1]  <= b_d[i];
      end
    end
  end

  assign quo   = qacc[PIXEL_BITS];
  assign a_out = a_d[PIXEL_BITS];
  assign b_out = b_d[PIXEL_BITS];

endmodule

// ----- hw/rtl/olb_merge.sv -----
// Merge stage: picks each channel by region, then an output register and skid slot.
// Depends on olb_pkg.
module olb_merge import olb_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  olb_ctl_t                            ctl,
  input  logic [CHANNELS-1:0][PIXEL_BITS-1:0] quo,
  input  logic [CHANNELS-1:0][PIXEL_BITS-1:0] a_px,
  input  logic [CHANNELS-1:0][PIXEL_BITS-1:0] b_px,
  input  logic                                out_stall,
  output logic                                skid_full,
  output logic                                out_valid,
  output logic [CHANNELS-1:0][PIXEL_BITS-1:0] out_px,
  output region_t                             out_region
);

  logic [CHANNELS-1:0][PIXEL_BITS-1:0] sel_px, skid_px;
  region_t                             skid_region;
  logic                                push, load;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      case (ctl.region)
        REG_BLEND: sel_px[c] = quo[c];
        REG_A:     sel_px[c] = a_px[c];
        REG_B:     sel_px[c] = b_px[c];
        default:   sel_px[c] = '0;
      endcase
    end
  end

  // The pipeline only advances while the skid slot is empty.
  assign push = ctl.valid && !skid_full;
  assign load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (load) begin
      out_valid <= skid_full || push;
      skid_full <= 1'b0;
    end else if (push) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (skid_full) begin
        out_px     <= skid_px;
        out_region <= skid_region;
      end else begin
        out_px     <= sel_px;
        out_region <= ctl.region;
      end
    end else if (push) begin
      skid_px     <= sel_px;
      skid_region <= ctl.region;
    end
  end

endmodule

// ----- hw/rtl/image_overlap_linear_blend.sv -----
// Top level of the two-image overlap linear blend: config registers and lane array.
// Depends on olb_pkg, olb_classify, olb_lane and olb_merge.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   in      | in_valid / in_stall    | pos_x, pos_y, a_red..a_blue, b_red..b_blue
//   out     | out_valid / out_stall  | out_red, out_green, out_blue, region
//   config  | cfg_we (no handshake)  | cfg_index, cfg_data
//
// One item per clock while the skid slot is empty; each item passes through the
// classify stage, the weighted-sum stage, one restoring divide step per
// quotient bit in each color lane, and the output register.
// Reset clears all valid flags and loads the register defaults.
// in_stall rises only while the skid slot holds an item behind a stalled output.
module image_overlap_linear_blend import olb_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [POS_W-1:0]      pos_x,
  input  logic [POS_W-1:0]      pos_y,
  input  logic [PIXEL_BITS-1:0] a_red,
  input  logic [PIXEL_BITS-1:0] a_green,
  input  logic [PIXEL_BITS-1:0] a_blue,
  input  logic [PIXEL_BITS-1:0] b_red,
  input  logic [PIXEL_BITS-1:0] b_green,
  input  logic [PIXEL_BITS-1:0] b_blue,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIXEL_BITS-1:0] out_red,
  output logic [PIXEL_BITS-1:0] out_green,
  output logic [PIXEL_BITS-1:0] out_blue,
  output logic [1:0]            region,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int LANE_LAT = PIXEL_BITS + 1;

  logic [DIM_W-1:0] width_a, height_a, height_b, shift_x;
  logic [SHY_W-1:0] shift_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_a  <= DIM_W'(640);
      height_a <= DIM_W'(480);
      height_b <= DIM_W'(480);
      shift_x  <= '0;
      shift_y  <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_WIDTH_A:  width_a  <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT_A: height_a <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT_B: height_b <= cfg_data[DIM_W-1:0];
        CFG_SHIFT_X:  shift_x  <= cfg_data[DIM_W-1:0];
        CFG_SHIFT_Y:  shift_y  <= cfg_data[SHY_W-1:0];
        default: ;
      endcase
    end
  end

  logic                                en, skid_full;
  logic [CHANNELS-1:0][PIXEL_BITS-1:0] a_in, b_in, a_px, b_px;
  logic [CHANNELS-1:0][PIXEL_BITS-1:0] quo, a_lane, b_lane, out_px;
  logic [DIM_W-1:0]                    wt_a, wt_b;
  olb_ctl_t                            ctl_cls;
  olb_ctl_t                            ctl_d [LANE_LAT];
  region_t                             out_region;

  assign en       = !skid_full;
  assign in_stall = skid_full;

  assign a_in = {a_blue, a_green, a_red};
  assign b_in = {b_blue, b_green, b_red};

  olb_classify #(.PIXEL_BITS(PIXEL_BITS)) u_classify (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .a_in     (a_in),
    .b_in     (b_in),
    .width_a  (width_a),
    .height_a (height_a),
    .height_b (height_b),
    .shift_x  (shift_x),
    .shift_y  (shift_y),
    .ctl      (ctl_cls),
    .wt_a     (wt_a),
    .wt_b     (wt_b),
    .a_px     (a_px),
    .b_px     (b_px)
  );

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    olb_lane #(.PIXEL_BITS(PIXEL_BITS)) u_lane (
      .clk     (clk),
      .en      (en),
      .shift_x (shift_x),
      .a_in    (a_px[c]),
      .b_in    (b_px[c]),
      .wt_a    (wt_a),
      .wt_b    (wt_b),
      .quo     (quo[c]),
      .a_out   (a_lane[c]),
      .b_out   (b_lane[c])
    );
  end

  // Region and valid travel alongside the lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        ctl_d[i].valid <= 1'b0;
      end
    end else if (en) begin
      ctl_d[0].valid <= ctl_cls.valid;
      for (int i = 1; i < LANE_LAT; i++) begin
        ctl_d[i].valid <= ctl_d[i-1].valid;
      end
    end
    if (en) begin
      ctl_d[0].region <= ctl_cls.region;
      for (int i = 1; i < LANE_LAT; i++) begin
        ctl_d[i].region <= ctl_d[i-1].region;
      end
    end
  end

  olb_merge #(.PIXEL_BITS(PIXEL_BITS)) u_merge (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl_d[LANE_LAT-1]),
    .quo        (quo),
    .a_px       (a_lane),
    .b_px       (b_lane),
    .out_stall  (out_stall),
    .skid_full  (skid_full),
    .out_valid  (out_valid),
    .out_px     (out_px),
    .out_region (out_region)
  );

  assign out_red   = out_px[0];
  assign out_green = out_px[1];
  assign out_blue  = out_px[2];
  assign region    = out_region;

endmodule

// ----- tb/image_overlap_linear_blend_tb.sv -----
// Self-checking testbench for image_overlap_linear_blend: directed region and register
// cases, then random canvas positions under random stalls. Depends on olb_pkg and the RTL.
module image_overlap_linear_blend_tb;
  import olb_pkg::*;

  localparam int PIX_W         = 8;
  localparam int LATENCY       = PIX_W + 3;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 160;
  localparam int MAX_POS       = (1 << POS_W) - 1;
  localparam int MAX_LEVEL     = (1 << PIX_W) - 1;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [PIX_W-1:0] ar, ag, ab;
    logic [PIX_W-1:0] br, bg, bb;
  } pixel_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red, green, blue;
    region_t          zone;
  } pixel_out_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [POS_W-1:0]     pos_x = '0;
  logic [POS_W-1:0]     pos_y = '0;
  logic [PIX_W-1:0]     a_red = '0, a_green = '0, a_blue = '0;
  logic [PIX_W-1:0]     b_red = '0, b_green = '0, b_blue = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_W-1:0]     out_red, out_green, out_blue;
  logic [1:0]           region;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Local copy of the block's registers, loaded with the reset defaults.
  logic [DIM_W-1:0]        m_width_a  = DIM_W'(640);
  logic [DIM_W-1:0]        m_height_a = DIM_W'(480);
  logic [DIM_W-1:0]        m_height_b = DIM_W'(480);
  logic [DIM_W-1:0]        m_shift_x  = '0;
  logic signed [SHY_W-1:0] m_shift_y  = '0;

  pixel_out_t expected_pixels[$];
  bit         steady = 1'b0;
  int         mismatch_count = 0;
  int         items_sent = 0;
  int         results_checked = 0;
  int         settings_used = 0;
  int         cycle_count = 0;

  image_overlap_linear_blend #(.PIXEL_BITS(PIX_W)) dut (
    .clk, .rst, .in_valid, .in_stall, .pos_x, .pos_y,
    .a_red, .a_green, .a_blue, .b_red, .b_green, .b_blue,
    .out_valid, .out_stall, .out_red, .out_green, .out_blue, .region,
    .cfg_we, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               expected_pixels.size());
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 28);
  end

  function automatic logic [PIX_W-1:0] mix_level(int a, int b, int wa, int wb, int d);
    return PIX_W'((a * wa + b * wb) / d);
  endfunction

  // Classifies the canvas position and forms the stitched color for the current registers.
  function automatic pixel_out_t predict_blend(pixel_in_t px);
    pixel_out_t res;
    int x, y, wa, ha, hb, dx, dy, off;
    bit in_a, b_ok;
    x   = px.x;
    y   = px.y;
    wa  = m_width_a;
    ha  = m_height_a;
    hb  = m_height_b;
    dx  = m_shift_x;
    dy  = m_shift_y;
    off = wa - dx;
    if (dy <= 0) begin
      in_a = (x < wa) && (y < ha);
      b_ok = (x >= off) && (y >= -dy) && (y < hb - dy);
    end else begin
      in_a = (x < wa) && (y >= dy);
      b_ok = (x >= off) && (y < hb);
    end
    if (in_a) res.zone = b_ok ? REG_BLEND : REG_A;
    else res.zone = b_ok ? REG_B : REG_BLACK;
    case (res.zone)
      REG_BLEND: begin
        res.red   = mix_level(px.ar, px.br, wa - x, x - off, dx);
        res.green = mix_level(px.ag, px.bg, wa - x, x - off, dx);
        res.blue  = mix_level(px.ab, px.bb, wa - x, x - off, dx);
      end
      REG_A: begin
        res.red   = px.ar;
        res.green = px.ag;
        res.blue  = px.ab;
      end
      REG_B: begin
        res.red   = px.br;
        res.green = px.bg;
        res.blue  = px.bb;
      end
      default: begin
        res.red   = '0;
        res.green = '0;
        res.blue  = '0;
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < 40)
      $display("[%0d] %s mismatch on result %0d: got %0d, expected %0d", cycle_count, what,
               results_checked, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    pixel_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result", region, -1);
      end else begin
        want = expected_pixels.pop_front();
        if (out_red !== want.red) report_mismatch("red", out_red, want.red);
        if (out_green !== want.green) report_mismatch("green", out_green, want.green);
        if (out_blue !== want.blue) report_mismatch("blue", out_blue, want.blue);
        if (region !== want.zone) report_mismatch("region", region, want.zone);
      end
      results_checked++;
    end
  end

  task automatic send_pixel(pixel_in_t px);
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x    <= px.x;
    pos_y    <= px.y;
    a_red    <= px.ar;
    a_green  <= px.ag;
    a_blue   <= px.ab;
    b_red    <= px.br;
    b_green  <= px.bg;
    b_blue   <= px.bb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_pixels.push_back(predict_blend(px));
    items_sent++;
  endtask

  function automatic pixel_in_t mk(int x, int y, logic [23:0] a, logic [23:0] b);
    pixel_in_t px;
    px.x = POS_W'(x);
    px.y = POS_W'(y);
    {px.ar, px.ag, px.ab} = a;
    {px.br, px.bg, px.bb} = b;
    return px;
  endfunction

  task automatic put_reg(cfg_index_t idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(posedge clk);
  endtask

  // Registers change only once every pending result has come back.
  task automatic write_config(int wa, int ha, int hb, int dx, int dy);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    put_reg(CFG_WIDTH_A, wa);
    put_reg(CFG_HEIGHT_A, ha);
    put_reg(CFG_HEIGHT_B, hb);
    put_reg(CFG_SHIFT_X, dx);
    put_reg(CFG_SHIFT_Y, dy);
    cfg_we     <= 1'b0;
    m_width_a  = DIM_W'(wa);
    m_height_a = DIM_W'(ha);
    m_height_b = DIM_W'(hb);
    m_shift_x  = DIM_W'(dx);
    m_shift_y  = SHY_W'(dy);
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    send_pixel(mk(0, 0, 24'h000000, 24'hffffff));
    send_pixel(mk(639, 479, 24'hffffff, 24'h000000));
    send_pixel(mk(640, 0, 24'h123456, 24'hfedcba));
    send_pixel(mk(640, 480, 24'hffffff, 24'hffffff));
    send_pixel(mk(MAX_POS, MAX_POS, 24'hffffff, 24'hffffff));
  endtask

  task automatic test_blend_b_raised();
    write_config(100, 50, 30, 20, -5);
    send_pixel(mk(80, 10, 24'hffffff, 24'h000000));
    send_pixel(mk(99, 34, 24'hff00ff, 24'h00ff80));
    // Inside A and within the overlap columns, but the B row is out of range.
    send_pixel(mk(90, 40, 24'h11aa55, 24'hffffff));
    send_pixel(mk(90, 2, 24'h2266cc, 24'hffffff));
    send_pixel(mk(150, 10, 24'h000000, 24'h89abcd));
    send_pixel(mk(150, 40, 24'hffffff, 24'hffffff));
    send_pixel(mk(MAX_POS, 20, 24'h000000, 24'h5a5a5a));
  endtask

  task automatic test_blend_a_lowered();
    write_config(64, 40, 50, 16, 7);
    send_pixel(mk(50, 20, 24'hffffff, 24'h000000));
    send_pixel(mk(50, 3, 24'hffffff, 24'h3c3c3c));
    send_pixel(mk(10, 20, 24'h7f7f7f, 24'hffffff));
    send_pixel(mk(10, 3, 24'hffffff, 24'hffffff));
    send_pixel(mk(70, 60, 24'hffffff, 24'hffffff));
    send_pixel(mk(63, 49, 24'h0f0f0f, 24'hf0f0f0));
  endtask

  task automatic test_register_extremes();
    // Zero sizes and zero overlap width leave nothing but black.
    write_config(0, 0, 0, 0, 0);
    send_pixel(mk(0, 0, 24'hffffff, 24'hffffff));
    write_config(MAX_POS, MAX_POS, MAX_POS, MAX_POS, -(1 << (SHY_W - 1)));
    send_pixel(mk(0, 0, 24'hffffff, 24'h000000));
    send_pixel(mk(MAX_POS, MAX_POS - 1, 24'habcdef, 24'h000000));
    // Overlap wider than image A puts the blend start left of the canvas.
    write_config(4096, 4096, MAX_POS, MAX_POS, 4096);
    send_pixel(mk(0, 4096, 24'hffffff, 24'hfefefe));
    send_pixel(mk(MAX_POS, 0, 24'h000000, 24'hffffff));
  endtask

  function automatic logic [PIX_W-1:0] rand_level();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? PIX_W'(MAX_LEVEL) : '0;
    return PIX_W'($urandom_range(0, MAX_LEVEL));
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(int v);
    if (v < 0) return '0;
    if (v > MAX_POS) return POS_W'(MAX_POS);
    return POS_W'(v);
  endfunction

  // Positions cluster around the overlap band and the image edges; a few span the canvas.
  function automatic pixel_in_t random_pixel();
    pixel_in_t px;
    int wa, dx, off, dy, span, pick, lo;
    wa   = m_width_a;
    dx   = m_shift_x;
    dy   = m_shift_y;
    off  = wa - dx;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      lo   = (off < 2) ? 0 : off - 2;
      px.x = clamp_pos(lo + $urandom_range(0, wa + 1 - lo + 1));
    end else if (pick < 85) begin
      px.x = clamp_pos($urandom_range(0, wa + 2 * ((dx < 8) ? 8 : dx)));
    end else begin
      px.x = POS_W'($urandom_range(0, MAX_POS));
    end
    span = ((m_height_a > m_height_b) ? m_height_a : m_height_b) + ((dy < 0) ? -dy : dy) + 4;
    if ($urandom_range(0, 99) < 80) px.y = clamp_pos($urandom_range(0, span));
    else px.y = POS_W'($urandom_range(0, MAX_POS));
    px.ar = rand_level();
    px.ag = rand_level();
    px.ab = rand_level();
    px.br = rand_level();
    px.bg = rand_level();
    px.bb = rand_level();
    return px;
  endfunction

  task automatic random_config();
    int sel, wa, ha, hb, dx, dy, lim;
    sel = $urandom_range(0, 9);
    if (sel < 5) wa = $urandom_range(1, 64);
    else if (sel < 9) wa = $urandom_range(1, 4096);
    else wa = $urandom_range(0, MAX_POS);
    lim = (sel < 5) ? 80 : 4096;
    ha  = $urandom_range((sel == 9) ? 0 : 1, lim);
    hb  = $urandom_range((sel == 9) ? 0 : 1, lim);
    dx  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, wa) : $urandom_range(0, MAX_POS);
    dy  = int'($urandom_range(0, 2 * lim)) - lim;
    write_config(wa, ha, hb, dx, dy);
  endtask

  task automatic test_random_blends();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) write_config(4096, 4096, 4096, 4096, -4096);
      else if (phase == 1) write_config(4096, 1, 4096, 1, 4096);
      else random_config();
      steady = (phase == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) send_pixel(random_pixel());
    end
    steady = 1'b0;
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_blend_b_raised();
    test_blend_a_lowered();
    test_register_extremes();
    test_random_blends();
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    $display("Sent %0d pixels under %0d register settings and checked %0d results.",
             items_sent, settings_used, results_checked);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d field errors logged", mismatch_count);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
